// ----- design/kskn_pkg.sv -----
`timescale 1ns / 1ps

package kskn_pkg;

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_NAME,
      MODE_NUM,
      MODE_LPAREN,
      MODE_GT,
      MODE_LT,
      MODE_COLON,
      MODE_COMMENT,
      MODE_STAR
   } mode_type;

   localparam logic [5:0] KIND_BAD     = 6'd0;
   localparam logic [5:0] KIND_END     = 6'd1;
   localparam logic [5:0] KIND_INT     = 6'd2;
   localparam logic [5:0] KIND_IDENT   = 6'd3;
   localparam logic [5:0] KIND_KW_BASE = 6'd4;
   localparam logic [5:0] KIND_UNDER   = 6'd23;
   localparam logic [5:0] KIND_LPAREN  = 6'd24;
   localparam logic [5:0] KIND_RPAREN  = 6'd25;
   localparam logic [5:0] KIND_COMMA   = 6'd26;
   localparam logic [5:0] KIND_PERIOD  = 6'd27;
   localparam logic [5:0] KIND_EQUAL   = 6'd28;
   localparam logic [5:0] KIND_GEQ     = 6'd29;
   localparam logic [5:0] KIND_GT      = 6'd30;
   localparam logic [5:0] KIND_LEQ     = 6'd31;
   localparam logic [5:0] KIND_LT      = 6'd32;
   localparam logic [5:0] KIND_ASSIGN  = 6'd33;
   localparam logic [5:0] KIND_COLON   = 6'd34;
   localparam logic [5:0] KIND_PLUS    = 6'd35;
   localparam logic [5:0] KIND_MINUS   = 6'd36;
   localparam logic [5:0] KIND_TIMES   = 6'd37;
   localparam logic [5:0] KIND_LBRACE  = 6'd38;
   localparam logic [5:0] KIND_RBRACE  = 6'd39;
   localparam logic [5:0] KIND_LBRACK  = 6'd40;
   localparam logic [5:0] KIND_RBRACK  = 6'd41;
   localparam logic [5:0] KIND_QUOTE   = 6'd42;
   localparam logic [5:0] KIND_BAR     = 6'd43;

   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_UNDER  = 8'h5F;

   localparam int NUM_KEYWORDS = 19;
   localparam int KW_MAX_CHARS = 7;

   // Keyword spellings, last character in the lowest byte.
   localparam logic [55:0] KW_TEXT [NUM_KEYWORDS] = '{
      56'("MODULE"), 56'("IF"), 56'("THEN"), 56'("ELIF"), 56'("ELSE"),
      56'("CONST"), 56'("FUNC"), 56'("PROC"), 56'("TYPE"), 56'("VAR"),
      56'("REPEAT"), 56'("UNTIL"), 56'("WHILE"), 56'("DO"), 56'("BEGIN"),
      56'("END"), 56'("ARRAY"), 56'("POINTER"), 56'("RECORD")
   };
   localparam int KW_LEN [NUM_KEYWORDS] = '{
      6, 2, 4, 4, 4, 5, 4, 4, 4, 3, 6, 5, 5, 2, 5, 3, 5, 7, 6
   };

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [5:0]  token_kind;
      logic [49:0] number_value;
      logic [4:0]  ident_length;
      logic [63:0] ident_text_low;
      logic [63:0] ident_text_high;
      logic [7:0]  bad_char;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [5:0]   kind;
      logic [49:0]  num;
      logic [4:0]   len;
      logic [127:0] text;
      logic [7:0]   bad;
   } tok_type;

   // Tokens caused by one input byte: one, or two when pair is set.
   typedef struct packed {
      logic    pair;
      tok_type t0;
      tok_type t1;
   } group_type;

   // Kind of a single-character symbol; bad for anything unexpected.
   function automatic logic [5:0] char_kind(input logic [7:0] c);
      logic [5:0] k;
      case (c)
         8'h5F:   k = KIND_UNDER;
         8'h28:   k = KIND_LPAREN;
         8'h29:   k = KIND_RPAREN;
         8'h2C:   k = KIND_COMMA;
         8'h2E:   k = KIND_PERIOD;
         8'h3D:   k = KIND_EQUAL;
         8'h3E:   k = KIND_GT;
         8'h3C:   k = KIND_LT;
         8'h3A:   k = KIND_COLON;
         8'h2B:   k = KIND_PLUS;
         8'h2D:   k = KIND_MINUS;
         8'h2A:   k = KIND_TIMES;
         8'h7B:   k = KIND_LBRACE;
         8'h7D:   k = KIND_RBRACE;
         8'h5B:   k = KIND_LBRACK;
         8'h5D:   k = KIND_RBRACK;
         8'h27:   k = KIND_QUOTE;
         8'h7C:   k = KIND_BAR;
         default: k = KIND_BAD;
      endcase
      return k;
   endfunction

   // Identifier or keyword kind for a name of len characters.
   function automatic logic [5:0] kw_lookup(input logic [4:0] len, input logic [127:0] text);
      logic [5:0] k;
      logic       hit;
      k = KIND_IDENT;
      for (int w = NUM_KEYWORDS - 1; w >= 0; w--) begin
         hit = (len == 5'(KW_LEN[w]));
         for (int i = 0; i < KW_MAX_CHARS; i++) begin
            if (i < KW_LEN[w]) begin
               hit = hit && (text[8*i +: 8] == KW_TEXT[w][8*(KW_LEN[w]-1-i) +: 8]);
            end
         end
         if (hit) begin
            k = KIND_KW_BASE + 6'(w);
         end
      end
      return k;
   endfunction

endpackage

// ----- design/keyword_token_scanner.sv -----
`timescale 1ns / 1ps

// Streaming lexical scanner. Each req beat carries one ASCII byte or an end
// mark; each rsp beat carries one token, and last_of_run marks the final token
// caused by a given input beat. Whitespace and (* *) comments yield no token.
// A new input beat is taken every cycle as long as the two-entry token queue
// between the scanning front end and the output stage has room; an input beat
// that causes two tokens sends them as two rsp beats in turn. With rsp_ready
// high, the rate is one input beat per cycle with at most one token per beat.
// Digit runs are valued in the base held in the csr register (reset 10,
// clamped to 2..10), with one multiply-add on the accumulator per digit.
// Keywords are recognized in the output stage from the registered token.
// There is no clearing pass after reset.
module keyword_token_scanner #(
   parameter int MAX_NAME_CHARS = 16,
   parameter int MAX_DIGITS     = 15
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  kskn_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output kskn_pkg::rsp_type  rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [3:0]         csr_data
);

   logic [3:0] base_ff, base_in;
   logic       push, pop, full, empty;
   kskn_pkg::group_type push_data, pop_data;

   // The base register accepts a write beat in every cycle.
   assign csr_ready = 1'b1;
   assign base_in   = (csr_valid && csr_ready) ? csr_data : base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= 4'd10;
      end else begin
         base_ff <= base_in;
      end
   end

   // Front end: mode machine, name buffer and digit accumulator.
   kskn_front #(
      .MAX_NAME_CHARS(MAX_NAME_CHARS),
      .MAX_DIGITS(MAX_DIGITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .in_valid(req_valid),
      .in_ready(req_ready),
      .in_data(req_data),
      .base(base_ff),
      .queue_full(full),
      .push(push),
      .push_data(push_data)
   );

   // Token groups wait here so each side can stall on its own.
   kskn_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_data(push_data),
      .full(full),
      .pop(pop),
      .pop_data(pop_data),
      .empty(empty)
   );

   // Output stage: keyword lookup, text masking and beat sequencing.
   kskn_back u_back (
      .clock(clock),
      .reset(reset),
      .queue_empty(empty),
      .pop_data(pop_data),
      .pop(pop),
      .out_valid(rsp_valid),
      .out_ready(rsp_ready),
      .out_data(rsp_data)
   );

endmodule

// ----- design/kskn_queue.sv -----
`timescale 1ns / 1ps

module kskn_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  kskn_pkg::group_type  push_data,
   output logic                 full,
   input  logic                 pop,
   output kskn_pkg::group_type  pop_data,
   output logic                 empty
);

   kskn_pkg::group_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- design/kskn_front.sv -----
`timescale 1ns / 1ps

module kskn_front #(
   parameter int MAX_NAME_CHARS = 16,
   parameter int MAX_DIGITS     = 15
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  kskn_pkg::req_type    in_data,
   input  logic [3:0]           base,
   input  logic                 queue_full,
   output logic                 push,
   output kskn_pkg::group_type  push_data
);

   kskn_pkg::mode_type mode_ff, mode_in, start_mode;
   logic [127:0] buf_ff, buf_in, buf_new;
   logic [4:0]   ncnt_ff, ncnt_in, ncnt_new;
   logic [49:0]  acc_ff, acc_in, acc_src, acc_new, acc_upd;
   logic [3:0]   dcnt_ff, dcnt_in, dcnt_new;
   logic         stop_ff, stop_in, stop_src, valued;

   logic [7:0] c;
   logic       eoi, accept;
   logic       is_dig, is_alp, is_sp, is_word;
   logic [3:0] base_eff, d, nidx;
   logic       cont, pend, start, let_add, dig_limit, name_limit;
   logic [5:0] sym;
   kskn_pkg::tok_type tok_f, tok_c, tok_s, tok_e;
   logic       c_v, s_v;

   assign c       = in_data.char_code;
   assign eoi     = in_data.end_of_input;
   assign in_ready = !queue_full;
   assign accept  = in_valid && in_ready;

   assign is_dig  = (c >= 8'h30) && (c <= 8'h39);
   assign is_alp  = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
   assign is_sp   = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   assign is_word = is_alp || is_dig || (c == kskn_pkg::CH_UNDER);
   assign sym     = kskn_pkg::char_kind(c);
   assign d       = c[3:0];
   assign base_eff = (base < 4'd2) ? 4'd2 : ((base > 4'd10) ? 4'd10 : base);

   always_comb begin
      case (mode_ff)
         kskn_pkg::MODE_NAME:    cont = is_word;
         kskn_pkg::MODE_NUM:     cont = is_dig;
         kskn_pkg::MODE_LPAREN:  cont = (c == kskn_pkg::CH_STAR);
         kskn_pkg::MODE_GT,
         kskn_pkg::MODE_LT,
         kskn_pkg::MODE_COLON:   cont = (c == kskn_pkg::CH_EQUAL);
         kskn_pkg::MODE_COMMENT,
         kskn_pkg::MODE_STAR:    cont = 1'b1;
         default:                cont = 1'b0;
      endcase
   end

   assign start = !eoi && !cont;
   assign pend  = (eoi || !cont) && (mode_ff != kskn_pkg::MODE_IDLE)
                  && (mode_ff != kskn_pkg::MODE_COMMENT) && (mode_ff != kskn_pkg::MODE_STAR);
   assign let_add = !eoi && (((mode_ff == kskn_pkg::MODE_NAME) && is_word) || (start && is_alp));

   // Digit datapath: one multiply by the narrow base and one add.
   assign acc_src   = start ? 50'd0 : acc_ff;
   assign stop_src  = start ? 1'b0 : stop_ff;
   assign valued    = !stop_src && (d < base_eff);
   assign acc_new   = acc_src * 50'(base_eff) + 50'(d);
   assign acc_upd   = valued ? acc_new : acc_src;
   assign dcnt_new  = (start ? 4'd0 : dcnt_ff) + 4'd1;
   assign dig_limit = (dcnt_new >= 4'(MAX_DIGITS));

   // Name datapath: the byte lands in its lane of the buffer.
   assign nidx       = start ? 4'd0 : ncnt_ff[3:0];
   assign ncnt_new   = {1'b0, nidx} + 5'd1;
   assign name_limit = (ncnt_new >= 5'(MAX_NAME_CHARS));

   always_comb begin
      buf_new = buf_ff;
      buf_new[8*nidx +: 8] = c;
   end

   always_comb begin
      if (is_dig) begin
         start_mode = dig_limit ? kskn_pkg::MODE_IDLE : kskn_pkg::MODE_NUM;
      end else if (is_alp) begin
         start_mode = name_limit ? kskn_pkg::MODE_IDLE : kskn_pkg::MODE_NAME;
      end else if (c == kskn_pkg::CH_LPAREN) begin
         start_mode = kskn_pkg::MODE_LPAREN;
      end else if (c == kskn_pkg::CH_GT) begin
         start_mode = kskn_pkg::MODE_GT;
      end else if (c == kskn_pkg::CH_LT) begin
         start_mode = kskn_pkg::MODE_LT;
      end else if (c == kskn_pkg::CH_COLON) begin
         start_mode = kskn_pkg::MODE_COLON;
      end else begin
         start_mode = kskn_pkg::MODE_IDLE;
      end
   end

   // Next state.
   always_comb begin
      if (eoi) begin
         mode_in = kskn_pkg::MODE_IDLE;
      end else begin
         case (mode_ff)
            kskn_pkg::MODE_NAME: begin
               if (is_word) mode_in = name_limit ? kskn_pkg::MODE_IDLE : kskn_pkg::MODE_NAME;
               else mode_in = start_mode;
            end
            kskn_pkg::MODE_NUM: begin
               if (is_dig) mode_in = dig_limit ? kskn_pkg::MODE_IDLE : kskn_pkg::MODE_NUM;
               else mode_in = start_mode;
            end
            kskn_pkg::MODE_LPAREN: begin
               mode_in = (c == kskn_pkg::CH_STAR) ? kskn_pkg::MODE_COMMENT : start_mode;
            end
            kskn_pkg::MODE_GT, kskn_pkg::MODE_LT, kskn_pkg::MODE_COLON: begin
               mode_in = (c == kskn_pkg::CH_EQUAL) ? kskn_pkg::MODE_IDLE : start_mode;
            end
            kskn_pkg::MODE_COMMENT: begin
               mode_in = (c == kskn_pkg::CH_STAR) ? kskn_pkg::MODE_STAR : kskn_pkg::MODE_COMMENT;
            end
            kskn_pkg::MODE_STAR: begin
               if (c == kskn_pkg::CH_RPAREN) mode_in = kskn_pkg::MODE_IDLE;
               else if (c == kskn_pkg::CH_STAR) mode_in = kskn_pkg::MODE_STAR;
               else mode_in = kskn_pkg::MODE_COMMENT;
            end
            default: mode_in = start_mode;
         endcase
      end
   end

   // Tokens: the one flushed from the held state, the one a continuing run
   // closes, the one the fresh byte starts, and the end mark.
   always_comb begin
      tok_f = '0;
      tok_c = '0;
      tok_s = '0;
      tok_e = '0;
      c_v   = 1'b0;
      s_v   = 1'b0;
      tok_e.kind = kskn_pkg::KIND_END;
      case (mode_ff)
         kskn_pkg::MODE_NAME: begin
            tok_f.kind = kskn_pkg::KIND_IDENT;
            tok_f.len  = ncnt_ff;
            tok_f.text = buf_ff;
            tok_c.kind = kskn_pkg::KIND_IDENT;
            tok_c.len  = ncnt_new;
            tok_c.text = buf_new;
            c_v        = name_limit;
         end
         kskn_pkg::MODE_NUM: begin
            tok_f.kind = kskn_pkg::KIND_INT;
            tok_f.num  = acc_ff;
            tok_c.kind = kskn_pkg::KIND_INT;
            tok_c.num  = acc_upd;
            c_v        = dig_limit;
         end
         kskn_pkg::MODE_LPAREN: begin
            tok_f.kind = kskn_pkg::KIND_LPAREN;
         end
         kskn_pkg::MODE_GT: begin
            tok_f.kind = kskn_pkg::KIND_GT;
            tok_c.kind = kskn_pkg::KIND_GEQ;
            c_v        = 1'b1;
         end
         kskn_pkg::MODE_LT: begin
            tok_f.kind = kskn_pkg::KIND_LT;
            tok_c.kind = kskn_pkg::KIND_LEQ;
            c_v        = 1'b1;
         end
         kskn_pkg::MODE_COLON: begin
            tok_f.kind = kskn_pkg::KIND_COLON;
            tok_c.kind = kskn_pkg::KIND_ASSIGN;
            c_v        = 1'b1;
         end
         default: begin
         end
      endcase
      if (is_sp) begin
         s_v = 1'b0;
      end else if (is_dig) begin
         tok_s.kind = kskn_pkg::KIND_INT;
         tok_s.num  = acc_upd;
         s_v        = dig_limit;
      end else if (is_alp) begin
         tok_s.kind = kskn_pkg::KIND_IDENT;
         tok_s.len  = ncnt_new;
         tok_s.text = buf_new;
         s_v        = name_limit;
      end else if ((c == kskn_pkg::CH_LPAREN) || (c == kskn_pkg::CH_GT)
                   || (c == kskn_pkg::CH_LT) || (c == kskn_pkg::CH_COLON)) begin
         s_v = 1'b0;
      end else begin
         tok_s.kind = sym;
         tok_s.bad  = (sym == kskn_pkg::KIND_BAD) ? c : 8'd0;
         s_v        = 1'b1;
      end
   end

   // Output group.
   always_comb begin
      push_data = '0;
      push      = 1'b0;
      if (eoi) begin
         push           = accept;
         push_data.pair = pend;
         push_data.t0   = pend ? tok_f : tok_e;
         push_data.t1   = tok_e;
      end else if (cont) begin
         push         = accept && c_v;
         push_data.t0 = tok_c;
      end else if (pend) begin
         push           = accept;
         push_data.pair = s_v;
         push_data.t0   = tok_f;
         push_data.t1   = tok_s;
      end else begin
         push         = accept && s_v;
         push_data.t0 = tok_s;
      end
   end

   always_comb begin
      acc_in  = (mode_in == kskn_pkg::MODE_NUM) ? acc_upd : 50'd0;
      stop_in = (mode_in == kskn_pkg::MODE_NUM) ? !valued : 1'b0;
      dcnt_in = (mode_in == kskn_pkg::MODE_NUM) ? dcnt_new : 4'd0;
      ncnt_in = (mode_in == kskn_pkg::MODE_NAME) ? ncnt_new : 5'd0;
      buf_in  = let_add ? buf_new : buf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= kskn_pkg::MODE_IDLE;
         acc_ff  <= 50'd0;
         stop_ff <= 1'b0;
         dcnt_ff <= 4'd0;
         ncnt_ff <= 5'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         stop_ff <= stop_in;
         dcnt_ff <= dcnt_in;
         ncnt_ff <= ncnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         buf_ff <= buf_in;
      end
   end

endmodule

// ----- design/kskn_back.sv -----
`timescale 1ns / 1ps

module kskn_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 queue_empty,
   input  kskn_pkg::group_type  pop_data,
   output logic                 pop,
   output logic                 out_valid,
   input  logic                 out_ready,
   output kskn_pkg::rsp_type    out_data
);

   kskn_pkg::group_type cur_ff, cur_in;
   logic              valid_ff, valid_in;
   logic              sub_ff, sub_in;
   logic              last, load;
   kskn_pkg::tok_type tok;
   logic [127:0]      text;

   assign out_valid = valid_ff;
   assign tok  = sub_ff ? cur_ff.t1 : cur_ff.t0;
   assign last = sub_ff || !cur_ff.pair;
   assign load = !valid_ff || (out_ready && last);
   assign pop  = load && !queue_empty;

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         text[8*i +: 8] = (5'(i) < tok.len) ? tok.text[8*i +: 8] : 8'd0;
      end
   end

   always_comb begin
      out_data.token_kind = (tok.kind == kskn_pkg::KIND_IDENT)
                            ? kskn_pkg::kw_lookup(tok.len, tok.text) : tok.kind;
      out_data.number_value    = tok.num;
      out_data.ident_length    = tok.len;
      out_data.ident_text_low  = text[63:0];
      out_data.ident_text_high = text[127:64];
      out_data.bad_char        = tok.bad;
      out_data.last_of_run     = last;
   end

   always_comb begin
      cur_in   = cur_ff;
      valid_in = valid_ff;
      sub_in   = sub_ff;
      if (load) begin
         cur_in   = pop_data;
         valid_in = !queue_empty;
         sub_in   = 1'b0;
      end else if (out_ready) begin
         sub_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sub_ff   <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

// ----- design/kskn_checker.sv -----
`timescale 1ns / 1ps

module kskn_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input kskn_pkg::rsp_type  rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.token_kind == kskn_pkg::KIND_END) |-> rsp_data.last_of_run)
      else $error("end token not last of run");

   a_int_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.token_kind == kskn_pkg::KIND_INT)
      |-> (rsp_data.ident_length == 5'd0) && (rsp_data.ident_text_low == 64'd0)
          && (rsp_data.bad_char == 8'd0))
      else $error("integer token carries text");

endmodule

bind keyword_token_scanner kskn_checker u_kskn_checker (.*);
